### design/array_min_priority_queue_core_assert.svh
// Assertion macros for the array minimum priority queue core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ARRAY_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define ARRAY_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define AMPQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define AMPQ_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### design/ampq_pkg.sv
// Shared types and constants for the array minimum priority queue core.
// Used by the channel interfaces and the core; depends on nothing.
package ampq_pkg;

    localparam int VALUE_W  = 32;
    localparam int CFG_W    = 5;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

### design/ampq_req_if.sv
// Request channel of the priority queue: valid/ready with action and value.
// Depends on ampq_pkg for the value type.
interface ampq_req_if
    import ampq_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   action;
    value_t value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

### design/ampq_rsp_if.sv
// Response channel of the priority queue: valid/ready with result, status, fill.
// Depends on ampq_pkg for field types and widths.
interface ampq_rsp_if
    import ampq_pkg::*;
();
    logic                valid;
    logic                ready;
    value_t              out_value;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, output out_value, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input out_value, input status, input fill_count,
                    output ready);
endinterface

### design/array_min_priority_queue_core.sv
// Minimum priority queue held as an unsorted array in a single-port-write RAM.
// Depends on ampq_pkg, ampq_req_if, ampq_rsp_if and the assertion macro header.
//
// Usage:
// The req channel carries one item per request: action 0 inserts value at the
// rear, action 1 removes the smallest held value (earliest on ties). Every item
// yields exactly one item on the rsp channel with the removed value (zero on an
// insert or an empty remove), a status code and the fill count after the step.
// The user writes the capacity register through cfg_we/cfg_wdata only while the
// queue is idle; the core does not enforce this. Zero acts as one and values
// above DEPTH act as DEPTH. An insert, a full insert and an empty remove finish
// directly in S_IDLE. A remove on n held entries at position p scans all n
// entries in S_SCAN through the registered RAM read, then moves the n - p - 1
// entries behind p down one place in S_SHIFT and hands over its result. The
// core takes one item at a time.
// The result waits in an output register; the next item is taken in the cycle
// the waiting result leaves, so a stalled receiver stalls the request side.
// Reset empties the queue and sets the capacity to 16; the RAM is not cleared.
module array_min_priority_queue_core
    import ampq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    ampq_req_if.sink         req,
    ampq_rsp_if.source       rsp
);

    `include "array_min_priority_queue_core_assert.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CFG_W-1:0]    cap_reg, cap_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       lag_idx_reg, lag_idx_next;
    logic                lag_valid_reg, lag_valid_next;
    value_t              min_reg, min_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic                out_valid_reg, out_valid_next;
    value_t              out_value_reg, out_value_next;
    status_t             out_status_reg, out_status_next;
    logic [FILL_W-1:0]   out_fill_reg, out_fill_next;

    logic [VALUE_W-1:0]  mem [DEPTH];
    value_t              rd_data_reg;
    logic [AW-1:0]       rd_addr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    value_t              mem_wdata;

    logic                accept;
    logic                full;
    logic                take;
    logic [CFG_W-1:0]    cap_eff;
    logic [CW-1:0]       count_dec;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_value  = out_value_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.fill_count = out_fill_reg;

    assign cap_eff   = (cap_reg == '0) ? CFG_W'(1) : cap_reg;
    assign full      = (count_reg >= CW'(DEPTH)) || (WW'(count_reg) >= WW'(cap_eff));
    assign count_dec = count_reg - CW'(1);
    assign rd_addr   = idx_reg[AW-1:0];
    assign take      = lag_valid_reg
                       && ((lag_idx_reg == '0) || (rd_data_reg < min_reg));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cap_next        = cap_reg;
        idx_next        = idx_reg;
        lag_idx_next    = lag_idx_reg;
        lag_valid_next  = lag_valid_reg;
        min_next        = min_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = req.value;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_we)
        begin
            cap_next = cfg_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_value_next = '0;
                    if (req.action == ACT_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        if (full)
                        begin
                            out_status_next = ST_FULL;
                            out_fill_next   = FILL_W'(count_reg);
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            count_next      = count_reg + CW'(1);
                            out_status_next = ST_OK;
                            out_fill_next   = FILL_W'(count_reg + CW'(1));
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_EMPTY;
                        out_fill_next   = FILL_W'(count_reg);
                    end
                    else
                    begin
                        state_next     = S_SCAN;
                        idx_next       = '0;
                        lag_valid_next = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                if (take)
                begin
                    min_next = rd_data_reg;
                    pos_next = lag_idx_reg;
                end
                if (idx_reg < count_reg)
                begin
                    idx_next       = idx_reg + CW'(1);
                    lag_valid_next = 1'b1;
                    lag_idx_next   = idx_reg[AW-1:0];
                end
                else
                begin
                    state_next     = S_SHIFT;
                    idx_next       = CW'(pos_next) + CW'(1);
                    lag_valid_next = 1'b0;
                end
            end
            S_SHIFT:
            begin
                mem_we    = lag_valid_reg;
                mem_waddr = lag_idx_reg - AW'(1);
                mem_wdata = rd_data_reg;
                if (idx_reg < count_reg)
                begin
                    idx_next       = idx_reg + CW'(1);
                    lag_valid_next = 1'b1;
                    lag_idx_next   = idx_reg[AW-1:0];
                end
                else
                begin
                    state_next      = S_IDLE;
                    lag_valid_next  = 1'b0;
                    count_next      = count_dec;
                    out_valid_next  = 1'b1;
                    out_value_next  = min_reg;
                    out_status_next = ST_OK;
                    out_fill_next   = FILL_W'(count_dec);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            cap_reg        <= CAP_RESET;
            idx_reg        <= '0;
            lag_idx_reg    <= '0;
            lag_valid_reg  <= 1'b0;
            min_reg        <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
            out_fill_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cap_reg        <= cap_next;
            idx_reg        <= idx_next;
            lag_idx_reg    <= lag_idx_next;
            lag_valid_reg  <= lag_valid_next;
            min_reg        <= min_next;
            pos_reg        <= pos_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_fill_reg   <= out_fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    `AMPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "count exceeds depth")
    `AMPQ_ASSERT_NEXT(a_remove_starts_scan,
        accept && (req.action == ACT_REMOVE) && (count_reg != '0),
        state_reg == S_SCAN, "remove on a nonempty queue did not start a scan")
    `AMPQ_ASSERT_NEXT(a_shift_ends_ok,
        (state_reg == S_SHIFT) && (idx_reg >= count_reg),
        out_valid_reg && (out_status_reg == ST_OK), "finished remove gave no result")

endmodule

### verif/ampq_queue_checker.sv
// Watches the request, result and capacity ports of the minimum priority queue core.
// Keeps its own copy of the queue, predicts each result and compares it field by field.
// Depends on ampq_pkg and the ampq_req_if and ampq_rsp_if interfaces.
module ampq_queue_checker
    import ampq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    ampq_req_if              req,
    ampq_rsp_if              rsp,
    output int               mismatches,
    output int               results_awaited,
    output int               full_inserts,
    output int               empty_removes,
    output int               values_removed
);

    typedef struct packed {
        value_t            out_value;
        status_t           status;
        logic [FILL_W-1:0] fill_count;
    } queue_result_t;

    queue_result_t    expected_results[$];
    value_t           held [DEPTH];
    int unsigned      held_n;
    logic [CFG_W-1:0] capacity;

    function automatic queue_result_t apply_request(input logic act, input value_t val);
        queue_result_t r;
        int unsigned   limit;
        int unsigned   pos;
        r.out_value = '0;
        r.status    = ST_OK;
        limit = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : capacity);
        if (act == ACT_INSERT)
        begin
            if (held_n >= limit)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                held[held_n] = val;
                held_n++;
            end
        end
        else if (held_n == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            pos = 0;
            for (int unsigned i = 1; i < held_n; i++)
            begin
                if (held[i] < held[pos])
                    pos = i;
            end
            r.out_value = held[pos];
            for (int unsigned i = pos; i + 1 < held_n; i++)
            begin
                held[i] = held[i + 1];
            end
            held_n--;
        end
        r.fill_count = FILL_W'(held_n);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        queue_result_t want;
        queue_result_t got;
        if (!rst_n)
        begin
            expected_results.delete();
            held_n         = 0;
            capacity       = CAP_RESET;
            mismatches     = 0;
            full_inserts   = 0;
            empty_removes  = 0;
            values_removed = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("Result item arrived with no request outstanding.");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.out_value !== want.out_value)
                    begin
                        $error("out_value: expected %0d, got %0d", want.out_value,
                               rsp.out_value);
                        mismatches++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        mismatches++;
                    end
                    if (rsp.fill_count !== want.fill_count)
                    begin
                        $error("fill_count: expected %0d, got %0d", want.fill_count,
                               rsp.fill_count);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                got = apply_request(req.action, req.value);
                if (got.status == ST_FULL)
                    full_inserts++;
                else if (got.status == ST_EMPTY)
                    empty_removes++;
                else if (req.action == ACT_REMOVE)
                    values_removed++;
                expected_results.push_back(got);
            end
            if (cfg_we)
                capacity = cfg_wdata;
        end
        results_awaited = expected_results.size();
    end

endmodule

### verif/array_min_priority_queue_core_tb.sv
// Top of the minimum priority queue testbench: clock, reset, stimulus and verdict.
// Drives the core and ampq_queue_checker through ampq_req_if and ampq_rsp_if.
// Depends on ampq_pkg, both interfaces, the core and ampq_queue_checker.
module array_min_priority_queue_core_tb;
    import ampq_pkg::*;

    localparam int DEPTH           = 16;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int SETTLE_CYCLES   = 2 * DEPTH + 8;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    int mismatches;
    int results_awaited;
    int full_inserts;
    int empty_removes;
    int values_removed;
    int cycles = 0;
    int items_sent;
    int capacity_writes;
    int send_idle_pct;
    int recv_idle_pct;

    logic [CFG_W-1:0] phase_caps [NUM_PHASES] = '{5'd16, 5'd31, 5'd1, 5'd4, 5'd0,
                                                  5'd17, 5'd9, 5'd16, 5'd2, 5'd12};

    ampq_req_if req_ch ();
    ampq_rsp_if rsp_ch ();

    array_min_priority_queue_core #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    ampq_queue_checker #(
        .DEPTH (DEPTH)
    ) checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .mismatches      (mismatches),
        .results_awaited (results_awaited),
        .full_inserts    (full_inserts),
        .empty_removes   (empty_removes),
        .values_removed  (values_removed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.", cycles,
                     results_awaited);
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic value_t pick_value();
        case ($urandom_range(5))
            0: return value_t'(32'h8000_0000);
            1: return value_t'(32'h7FFF_FFFF);
            2, 3: return value_t'($urandom_range(8)) - 4;
            default: return value_t'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic act, input value_t val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.action = act;
        req_ch.value  = val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (results_awaited != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        cfg_we    = 1'b1;
        cfg_wdata = cap;
        @(negedge clk);
        cfg_we = 1'b0;
        capacity_writes++;
    endtask

    initial
    begin : stimulus
        int left;
        int insert_pct;
        int burst;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_INSERT;
        req_ch.value    = '0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        items_sent      = 0;
        capacity_writes = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_item(ACT_REMOVE, value_t'($urandom));
        send_item(ACT_INSERT, value_t'(32'h7FFF_FFFF));
        send_item(ACT_INSERT, value_t'(32'h8000_0000));
        send_item(ACT_INSERT, value_t'(0));
        send_item(ACT_INSERT, value_t'(-1));
        send_item(ACT_INSERT, value_t'(32'h8000_0000));
        repeat (5) send_item(ACT_REMOVE, value_t'($urandom));
        send_item(ACT_INSERT, value_t'(3));
        send_item(ACT_INSERT, value_t'(3));
        send_item(ACT_INSERT, value_t'(-7));
        send_item(ACT_INSERT, value_t'(100));
        wait_idle();
        write_capacity(5'd2);
        send_item(ACT_INSERT, value_t'(42));
        repeat (3) send_item(ACT_REMOVE, value_t'($urandom));
        send_item(ACT_INSERT, value_t'(8));
        wait_idle();
        write_capacity(5'd0);
        send_item(ACT_INSERT, value_t'(9));
        repeat (2) send_item(ACT_REMOVE, value_t'($urandom));
        send_item(ACT_INSERT, value_t'(-9));
        send_item(ACT_INSERT, value_t'(11));

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            write_capacity(phase_caps[p]);
            if (p < 3)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 87;
            end
            else if (p < 6)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            left = ITEMS_PER_PHASE;
            while (left > 0)
            begin
                case ($urandom_range(2))
                    0: insert_pct = 80;
                    1: insert_pct = 50;
                    default: insert_pct = 20;
                endcase
                burst = $urandom_range(40, 5);
                for (int k = 0; k < burst && left > 0; k++)
                begin
                    if ($urandom_range(99) < insert_pct)
                        send_item(ACT_INSERT, pick_value());
                    else
                        send_item(ACT_REMOVE, value_t'($urandom));
                    left--;
                end
            end
        end

        req_ch.valid = 1'b0;
        while (results_awaited != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items in %0d cycles over %0d capacity settings, three idle mixes.",
                 items_sent, cycles, capacity_writes);
        $display("Removes returned %0d values; %0d inserts found it full, %0d removes empty.",
                 values_removed, full_inserts, empty_removes);
        if (mismatches == 0 && results_awaited == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/ampq_pkg.sv
design/ampq_req_if.sv
design/ampq_rsp_if.sv
design/array_min_priority_queue_core.sv
verif/ampq_queue_checker.sv
verif/array_min_priority_queue_core_tb.sv
